[src/ghsa_pkg.sv]
// Package for the generational handle slot allocator.
// Holds field widths, operation and status codes, default parameters and the
// command and status structs between controller and datapath. No dependencies.
`default_nettype none

package ghsa_pkg;

  localparam int SLOT_COUNT_DEF = 1024;
  localparam int GEN_BITS_DEF   = 20;

  localparam int OP_W     = 2;
  localparam int SLOT_W   = 10;
  localparam int HANDLE_W = 31;
  localparam int WORD_W   = 32;
  localparam int COUNT_W  = 11;
  localparam int STATUS_W = 2;

  // Widest row of the used-bit memory; the free search covers one row a cycle.
  localparam int ROW_MAX_W = 32;

  typedef enum logic [OP_W-1:0] {
    OP_ASSIGN  = 2'd0,
    OP_RELEASE = 2'd1,
    OP_QUERY   = 2'd2
  } op_t;

  localparam logic [STATUS_W-1:0] ST_VALID   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_STALE   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_INVALID = 2'd2;

  typedef struct packed {
    logic clear_wr;
    logic accept;
    logic scan_next;
    logic scan_take;
    logic assign_fin;
    logic full_fin;
    logic lookup_fin;
  } dp_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic scan_hit;
    logic scan_last;
    logic out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

[src/ghsa_req_if.sv]
// Request channel of the handle slot allocator: valid, ready and the fields
// of one request. Depends on ghsa_pkg.
`default_nettype none

interface ghsa_req_if;
  import ghsa_pkg::*;

  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     op;
  logic [SLOT_W-1:0]   slot_index;
  logic [HANDLE_W-1:0] handle_in;
  logic [WORD_W-1:0]   object_ref;
  logic [WORD_W-1:0]   owner_id;
  logic [HANDLE_W-1:0] parent_handle;

  modport source (
    output valid, op, slot_index, handle_in, object_ref, owner_id, parent_handle,
    input  ready
  );

  modport sink (
    input  valid, op, slot_index, handle_in, object_ref, owner_id, parent_handle,
    output ready
  );
endinterface

`default_nettype wire

[src/ghsa_rsp_if.sv]
// Response channel of the handle slot allocator: valid, ready and the fields
// of one result. Depends on ghsa_pkg.
`default_nettype none

interface ghsa_rsp_if;
  import ghsa_pkg::*;

  logic                valid;
  logic                ready;
  logic                ok;
  logic [HANDLE_W-1:0] handle_out;
  logic [SLOT_W-1:0]   slot_out;
  logic [STATUS_W-1:0] status;
  logic [WORD_W-1:0]   object_out;
  logic [WORD_W-1:0]   owner_out;
  logic [HANDLE_W-1:0] parent_out;
  logic [COUNT_W-1:0]  live_count;
  logic [COUNT_W-1:0]  peak_count;

  modport source (
    output valid, ok, handle_out, slot_out, status, object_out, owner_out,
           parent_out, live_count, peak_count,
    input  ready
  );

  modport sink (
    input  valid, ok, handle_out, slot_out, status, object_out, owner_out,
           parent_out, live_count, peak_count,
    output ready
  );
endinterface

`default_nettype wire

[src/ghsa_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Read data changes only on a read. No dependencies.
`default_nettype none

module ghsa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[src/ghsa_ctrl.sv]
// Controller of the handle slot allocator: sequences the clearing pass,
// request intake, free-slot scan and result loading. Depends on ghsa_pkg.
`default_nettype none

module ghsa_ctrl (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  logic [ghsa_pkg::OP_W-1:0] in_op,
  output logic                      in_ready,
  output ghsa_pkg::dp_cmd_t         cmd,
  input  ghsa_pkg::dp_stat_t        stat
);
  import ghsa_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_META,
    S_EVAL
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  assign accept = in_valid && in_ready;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        cmd.clear_wr = 1'b1;
        if (stat.clear_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        cmd.accept = accept;
        if (accept) begin
          state_next = (in_op == OP_ASSIGN) ? S_SCAN : S_EVAL;
        end
      end
      S_SCAN: begin
        if (stat.scan_hit) begin
          cmd.scan_take = 1'b1;
          state_next    = S_META;
        end else if (!stat.scan_last) begin
          cmd.scan_next = 1'b1;
        end else if (stat.out_free) begin
          cmd.full_fin = 1'b1;
          state_next   = S_IDLE;
        end
      end
      S_META: begin
        if (stat.out_free) begin
          cmd.assign_fin = 1'b1;
          state_next     = S_IDLE;
        end
      end
      S_EVAL: begin
        if (stat.out_free) begin
          cmd.lookup_fin = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      in_ready <= 1'b0;
    end else begin
      state    <= state_next;
      in_ready <= (state_next == S_IDLE);
    end
  end

endmodule

`default_nettype wire

[src/ghsa_dp.sv]
// Datapath of the handle slot allocator: used-bit, metadata and object
// memories, row-wise free search, counters and the result register.
// Depends on ghsa_pkg and ghsa_ram.
`default_nettype none

module ghsa_dp #(
  parameter int SLOT_COUNT = ghsa_pkg::SLOT_COUNT_DEF,
  parameter int GEN_BITS   = ghsa_pkg::GEN_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  ghsa_pkg::dp_cmd_t              cmd,
  output ghsa_pkg::dp_stat_t             stat,
  input  logic [ghsa_pkg::OP_W-1:0]      op,
  input  logic [ghsa_pkg::SLOT_W-1:0]    slot_index,
  input  logic [ghsa_pkg::HANDLE_W-1:0]  handle_in,
  input  logic [ghsa_pkg::WORD_W-1:0]    object_ref,
  input  logic [ghsa_pkg::WORD_W-1:0]    owner_id,
  input  logic [ghsa_pkg::HANDLE_W-1:0]  parent_handle,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           ok,
  output logic [ghsa_pkg::HANDLE_W-1:0]  handle_out,
  output logic [ghsa_pkg::SLOT_W-1:0]    slot_out,
  output logic [ghsa_pkg::STATUS_W-1:0]  status,
  output logic [ghsa_pkg::WORD_W-1:0]    object_out,
  output logic [ghsa_pkg::WORD_W-1:0]    owner_out,
  output logic [ghsa_pkg::HANDLE_W-1:0]  parent_out,
  output logic [ghsa_pkg::COUNT_W-1:0]   live_count,
  output logic [ghsa_pkg::COUNT_W-1:0]   peak_count
);
  import ghsa_pkg::*;

  localparam int IDX_W  = $clog2(SLOT_COUNT);
  localparam int TBL    = 1 << IDX_W;
  localparam int ROW_W  = (TBL < ROW_MAX_W) ? TBL : ROW_MAX_W;
  localparam int BIT_W  = $clog2(ROW_W);
  localparam int ROWS   = TBL / ROW_W;
  localparam int ROW_AW = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int VIS_W  = $clog2(ROWS + 1);
  localparam int CNT_W  = IDX_W + 1;
  localparam int GS     = IDX_W + 1;
  localparam int META_W = GEN_BITS + WORD_W + HANDLE_W;

  function automatic logic [ROW_AW-1:0] row_of(input logic [IDX_W-1:0] i);
    return ROW_AW'(i >> BIT_W);
  endfunction

  function automatic logic [BIT_W-1:0] bit_of(input logic [IDX_W-1:0] i);
    return i[BIT_W-1:0];
  endfunction

  function automatic logic [63:0] make_handle(input logic [GEN_BITS-1:0] g,
                                              input logic [IDX_W-1:0]    i);
    return (64'(g) << GS) | 64'(i);
  endfunction

  function automatic logic [GEN_BITS-1:0] next_gen(input logic [GEN_BITS-1:0] g);
    logic [GEN_BITS-1:0] n;
    n = g + GEN_BITS'(1);
    return (n == '0) ? GEN_BITS'(1) : n;
  endfunction

  // Memory ports.
  logic              u_we, u_re;
  logic [ROW_AW-1:0] u_waddr, u_raddr;
  logic [ROW_W-1:0]  u_wdata, u_rdata;
  logic              m_we, m_re;
  logic [IDX_W-1:0]  m_waddr, m_raddr;
  logic [META_W-1:0] m_wdata, m_rdata;
  logic              o_we, o_re;
  logic [IDX_W-1:0]  o_waddr, o_raddr;
  logic [WORD_W-1:0] o_wdata, o_rdata;

  // Control state.
  logic [IDX_W-1:0]  clr_cnt;
  logic [IDX_W-1:0]  start_q;
  logic [CNT_W-1:0]  live_q, peak_q;

  // Request and scan registers.
  logic [OP_W-1:0]     op_q;
  logic [IDX_W-1:0]    idx_q;
  logic [HANDLE_W-1:0] hdl_q;
  logic [WORD_W-1:0]   obj_q, own_q;
  logic [HANDLE_W-1:0] par_q;
  logic [ROW_AW-1:0]   scan_row;
  logic [VIS_W-1:0]    visit;
  logic [IDX_W-1:0]    hit_idx_q;

  // Combinational helpers.
  logic [IDX_W-1:0]    in_idx;
  logic [ROW_W-1:0]    ones, mask, free;
  logic                hit;
  logic [BIT_W-1:0]    hit_bit;
  logic [IDX_W-1:0]    hit_idx;
  logic [ROW_AW-1:0]   row_next;
  logic                scan_last;
  logic                cur_used;
  logic [GEN_BITS-1:0] gen_rd, gen_new;
  logic [WORD_W-1:0]   own_rd;
  logic [HANDLE_W-1:0] par_rd;
  logic [63:0]         h_cur, h_new, h_asg, hq, seq;
  logic                rel_ok, load;
  logic [CNT_W-1:0]    live_inc, live_after, peak_after;

  logic                res_ok;
  logic [63:0]         res_handle;
  logic [IDX_W-1:0]    res_slot;
  logic [STATUS_W-1:0] res_status;
  logic [WORD_W-1:0]   res_obj, res_own;
  logic [HANDLE_W-1:0] res_par;

  ghsa_ram #(.WIDTH(ROW_W), .DEPTH(ROWS)) u_used_ram (
    .clk(clk), .we(u_we), .waddr(u_waddr), .wdata(u_wdata),
    .re(u_re), .raddr(u_raddr), .rdata(u_rdata)
  );

  ghsa_ram #(.WIDTH(META_W), .DEPTH(TBL)) u_meta_ram (
    .clk(clk), .we(m_we), .waddr(m_waddr), .wdata(m_wdata),
    .re(m_re), .raddr(m_raddr), .rdata(m_rdata)
  );

  ghsa_ram #(.WIDTH(WORD_W), .DEPTH(TBL)) u_obj_ram (
    .clk(clk), .we(o_we), .waddr(o_waddr), .wdata(o_wdata),
    .re(o_re), .raddr(o_raddr), .rdata(o_rdata)
  );

  assign in_idx = (op == OP_RELEASE) ? IDX_W'(slot_index) : IDX_W'(handle_in);

  // The start row is visited twice: at and above the start bit first, below it last.
  assign ones      = '1;
  assign scan_last = (visit == VIS_W'(ROWS));

  always_comb begin
    if (visit == '0) begin
      mask = ones << start_q[BIT_W-1:0];
    end else if (scan_last) begin
      mask = ~(ones << start_q[BIT_W-1:0]);
    end else begin
      mask = ones;
    end
    free = ~u_rdata & mask;
  end

  always_comb begin
    hit_bit = '0;
    for (int i = ROW_W - 1; i >= 0; i--) begin
      if (free[i]) begin
        hit_bit = BIT_W'(i);
      end
    end
  end

  assign hit      = |free;
  assign hit_idx  = (IDX_W'(scan_row) << BIT_W) | IDX_W'(hit_bit);
  assign row_next = (scan_row + ROW_AW'(1)) & ROW_AW'(ROWS - 1);

  assign cur_used = u_rdata[bit_of(idx_q)];
  assign gen_rd   = m_rdata[META_W-1 -: GEN_BITS];
  assign own_rd   = m_rdata[HANDLE_W +: WORD_W];
  assign par_rd   = m_rdata[HANDLE_W-1:0];
  assign gen_new  = next_gen(gen_rd);
  assign h_cur    = make_handle(gen_rd, idx_q);
  assign h_new    = make_handle(gen_new, idx_q);
  assign h_asg    = make_handle(gen_rd, hit_idx_q);
  assign hq       = 64'(hdl_q);
  assign seq      = hq >> GS;

  assign rel_ok   = cmd.lookup_fin && (op_q == OP_RELEASE) && cur_used;
  assign load     = cmd.assign_fin || cmd.full_fin || cmd.lookup_fin;
  assign live_inc = live_q + CNT_W'(1);

  always_comb begin
    if (cmd.assign_fin) begin
      live_after = live_inc;
    end else if (rel_ok && (live_q != '0)) begin
      live_after = live_q - CNT_W'(1);
    end else begin
      live_after = live_q;
    end
    peak_after = (live_after > peak_q) ? live_after : peak_q;
  end

  // Memory address and write muxing.
  always_comb begin
    u_we    = 1'b0;
    u_waddr = scan_row;
    u_wdata = u_rdata | (ROW_W'(1) << hit_bit);
    m_we    = 1'b0;
    m_waddr = hit_idx_q;
    m_wdata = {gen_rd, own_q, par_q};
    o_we    = cmd.scan_take;
    o_waddr = hit_idx;
    o_wdata = obj_q;
    if (cmd.clear_wr) begin
      u_we    = (clr_cnt < IDX_W'(ROWS));
      u_waddr = ROW_AW'(clr_cnt);
      u_wdata = '0;
      m_we    = 1'b1;
      m_waddr = clr_cnt;
      m_wdata = {GEN_BITS'(1), {(WORD_W + HANDLE_W){1'b0}}};
    end else if (cmd.scan_take) begin
      u_we = 1'b1;
    end else if (cmd.assign_fin) begin
      m_we = 1'b1;
    end else if (rel_ok) begin
      u_we    = 1'b1;
      u_waddr = row_of(idx_q);
      u_wdata = u_rdata & ~(ROW_W'(1) << bit_of(idx_q));
      m_we    = 1'b1;
      m_waddr = idx_q;
      m_wdata = {gen_new, {(WORD_W + HANDLE_W){1'b0}}};
    end
  end

  always_comb begin
    u_re = cmd.accept || cmd.scan_next;
    if (cmd.accept) begin
      u_raddr = (op == OP_ASSIGN) ? row_of(start_q) : row_of(in_idx);
    end else begin
      u_raddr = row_next;
    end
    m_re    = cmd.accept || cmd.scan_take;
    m_raddr = cmd.accept ? in_idx : hit_idx;
    o_re    = cmd.accept;
    o_raddr = in_idx;
  end

  // Result of the finishing operation.
  always_comb begin
    res_ok     = 1'b0;
    res_handle = '0;
    res_slot   = '0;
    res_status = ST_VALID;
    res_obj    = '0;
    res_own    = '0;
    res_par    = '0;
    if (cmd.assign_fin) begin
      res_ok     = 1'b1;
      res_handle = h_asg;
      res_slot   = hit_idx_q;
    end else if (cmd.lookup_fin) begin
      case (op_t'(op_q))
        OP_RELEASE: begin
          res_slot   = idx_q;
          res_ok     = cur_used;
          res_handle = cur_used ? h_new : h_cur;
          res_obj    = cur_used ? o_rdata : '0;
        end
        OP_QUERY: begin
          res_ok     = 1'b1;
          res_slot   = idx_q;
          res_handle = h_cur;
          if (hq == h_cur) begin
            res_status = ST_VALID;
          end else if ((seq != 64'd0) && (seq < 64'(gen_rd))) begin
            res_status = ST_STALE;
          end else begin
            res_status = ST_INVALID;
          end
          res_obj = cur_used ? o_rdata : '0;
          res_own = own_rd;
          res_par = par_rd;
        end
        default: begin
          res_ok = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt   <= '0;
      start_q   <= '0;
      live_q    <= '0;
      peak_q    <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.clear_wr) begin
        clr_cnt <= clr_cnt + IDX_W'(1);
      end
      if (cmd.assign_fin) begin
        start_q <= hit_idx_q + IDX_W'(1);
      end
      if (load) begin
        live_q    <= live_after;
        peak_q    <= peak_after;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_q     <= op;
      idx_q    <= in_idx;
      hdl_q    <= handle_in;
      obj_q    <= object_ref;
      own_q    <= owner_id;
      par_q    <= parent_handle;
      scan_row <= row_of(start_q);
      visit    <= '0;
    end else if (cmd.scan_next) begin
      scan_row <= row_next;
      visit    <= visit + VIS_W'(1);
    end
    if (cmd.scan_take) begin
      hit_idx_q <= hit_idx;
    end
    if (load) begin
      ok         <= res_ok;
      handle_out <= HANDLE_W'(res_handle);
      slot_out   <= SLOT_W'(res_slot);
      status     <= res_status;
      object_out <= res_obj;
      owner_out  <= res_own;
      parent_out <= res_par;
      live_count <= COUNT_W'(live_after);
      peak_count <= COUNT_W'(peak_after);
    end
  end

  assign stat.clear_last = (clr_cnt == {IDX_W{1'b1}});
  assign stat.scan_hit   = hit;
  assign stat.scan_last  = scan_last;
  assign stat.out_free   = !out_valid;

endmodule

`default_nettype wire

[src/generational_handle_slot_allocator_core.sv]
// Generational handle slot allocator, top level.
// Requests arrive on req (op, slot_index, handle_in, object_ref, owner_id,
// parent_handle); one result per request leaves on rsp. A transfer takes place
// on a clock edge with valid and ready both high.
// Release and query: after the request transfer the controller waits until the
// output register is free, loads the result register and then opens the
// request side again. Assign scans the used-bit memory one row of up to 32
// slots per cycle, starting at the slot after the last one handed out; on a
// hit it reads that slot's metadata and then loads the result, and a full
// table is reported once the start row has been visited again below the
// start slot.
// After reset a clearing pass writes the used-bit and generation memories,
// one metadata slot and, while rows remain, one used-bit row per cycle, over
// SLOT_COUNT rounded up to a power of two slots (1024 by default); req.ready stays low until it ends.
// The result waits in an output register while rsp.ready is low; the block
// takes the next request and holds it just before its result would be loaded.
// Depends on ghsa_pkg, the channel interfaces, ghsa_ctrl and ghsa_dp.
`default_nettype none

module generational_handle_slot_allocator_core #(
  parameter int SLOT_COUNT = ghsa_pkg::SLOT_COUNT_DEF,
  parameter int GEN_BITS   = ghsa_pkg::GEN_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  ghsa_req_if.sink      req,
  ghsa_rsp_if.source    rsp
);
  import ghsa_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  ghsa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_op    (req.op),
    .in_ready (req.ready),
    .cmd      (cmd),
    .stat     (stat)
  );

  ghsa_dp #(
    .SLOT_COUNT (SLOT_COUNT),
    .GEN_BITS   (GEN_BITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .op            (req.op),
    .slot_index    (req.slot_index),
    .handle_in     (req.handle_in),
    .object_ref    (req.object_ref),
    .owner_id      (req.owner_id),
    .parent_handle (req.parent_handle),
    .out_valid     (rsp.valid),
    .out_ready     (rsp.ready),
    .ok            (rsp.ok),
    .handle_out    (rsp.handle_out),
    .slot_out      (rsp.slot_out),
    .status        (rsp.status),
    .object_out    (rsp.object_out),
    .owner_out     (rsp.owner_out),
    .parent_out    (rsp.parent_out),
    .live_count    (rsp.live_count),
    .peak_count    (rsp.peak_count)
  );

endmodule

`default_nettype wire

[src/ghsa_checker.sv]
// Port-level checks for the generational handle slot allocator and the bind
// that attaches them to the top level. Depends on ghsa_pkg.
`default_nettype none

module ghsa_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           req_valid,
  input logic                           req_ready,
  input logic                           rsp_valid,
  input logic                           rsp_ready,
  input logic                           ok,
  input logic [ghsa_pkg::HANDLE_W-1:0]  handle_out,
  input logic [ghsa_pkg::STATUS_W-1:0]  status,
  input logic [ghsa_pkg::COUNT_W-1:0]   live_count,
  input logic [ghsa_pkg::COUNT_W-1:0]   peak_count
);
  import ghsa_pkg::*;

  // The clearing pass keeps the request side closed straight after reset.
  a_closed_after_reset: assert property (@(posedge clk) rst |=> !req_ready)
    else $error("request accepted straight after reset");

  // A request transfer closes the request side while it is worked on.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("second request taken while one is in flight");

  // A stalled result keeps its contents until it is taken.
  a_result_held: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(handle_out) && $stable(ok))
    else $error("stalled result changed");

  a_peak_bound: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> live_count <= peak_count)
    else $error("live count above peak count");

  // Only queries report a status other than valid, and queries always succeed.
  a_status_ok: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (status != ST_VALID) |-> ok)
    else $error("non-valid status on a failed result");

endmodule

bind generational_handle_slot_allocator_core ghsa_checker u_ghsa_checker (
  .clk        (clk),
  .rst        (rst),
  .req_valid  (req.valid),
  .req_ready  (req.ready),
  .rsp_valid  (rsp.valid),
  .rsp_ready  (rsp.ready),
  .ok         (rsp.ok),
  .handle_out (rsp.handle_out),
  .status     (rsp.status),
  .live_count (rsp.live_count),
  .peak_count (rsp.peak_count)
);

`default_nettype wire
